// ===== rtl/core/dapc_pkg.sv =====
// Shared types, constants and lookup functions for the delay-adaptive P controller.
`default_nettype none

package dapc_pkg;

	// Joint count and the floor applied to the measured loop delay.
	localparam int unsigned NUM_JOINTS     = 6;
	localparam logic [19:0] DELAY_FLOOR_US = 20'd1000;
	localparam logic [19:0] MAX_ERR_SAT    = 20'hFFFFF;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W           = 2;
	localparam logic [1:0]  REG_GAIN_MARGIN     = 2'd0;
	localparam logic [1:0]  REG_ERROR_THRESHOLD = 2'd1;
	localparam logic [15:0] GAIN_MARGIN_RST     = 16'd26214;
	localparam logic [19:0] ERROR_THRESHOLD_RST = 20'd66;

	// Stream payload widths.
	localparam int unsigned S_TDATA_W = 64;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned TUSER_W   = 3;

	// Operand widths of the shared iterative unit.
	localparam int unsigned NUM_W = 37;
	localparam int unsigned DEN_W = 21;
	localparam int unsigned CNT_W = 6;
	localparam logic [5:0]  DIV_STEPS  = 6'd37;
	localparam logic [5:0]  SQRT_STEPS = 6'd18;

	// Operation codes of the shared iterative unit.
	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	// pi in Q30 and the dividends of the two divisions, with the 2^14 and 2^15
	// scalings of the divisor folded into the dividend.
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] OMEGA_NUM_W = (PI_Q30 * 64'd500000) >> 14;
	localparam logic [63:0] XN_1000_W   = (64'd1000 * PI_Q30) >> 15;
	localparam logic [63:0] XN_2000_W   = (64'd2000 * PI_Q30) >> 15;
	localparam logic [63:0] XN_3000_W   = (64'd3000 * PI_Q30) >> 15;
	localparam logic [36:0] OMEGA_NUM   = OMEGA_NUM_W[36:0];

	// Request to the shared iterative unit.
	typedef struct packed {
		logic             start;
		logic             op;
		logic [NUM_W-1:0] opnd;
		logic [DEN_W-1:0] den;
	} dapc_iter_req_t;

	// Response from the shared iterative unit.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] res;
	} dapc_iter_rsp_t;

	// Actuator time constant of a joint in microseconds.
	function automatic logic [11:0] joint_tau(input logic [2:0] sel);
		logic [11:0] t;
		case (sel)
			3'd0:    t = 12'd2000;
			3'd1:    t = 12'd2000;
			3'd2:    t = 12'd3000;
			3'd3:    t = 12'd2000;
			3'd4:    t = 12'd1000;
			default: t = 12'd1000;
		endcase
		return t;
	endfunction

	// Dividend for tau * omega, that is floor(tau * pi * 2^30 / 2^15).
	function automatic logic [36:0] joint_x_num(input logic [2:0] sel);
		logic [63:0] v;
		case (sel)
			3'd0:    v = XN_2000_W;
			3'd1:    v = XN_2000_W;
			3'd2:    v = XN_3000_W;
			3'd3:    v = XN_2000_W;
			3'd4:    v = XN_1000_W;
			default: v = XN_1000_W;
		endcase
		return v[36:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dapc_iter.sv =====
// Shared restoring unit that performs either a long division or an integer square root.
`default_nettype none

module dapc_iter (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dapc_pkg::dapc_iter_req_t req,
	output dapc_pkg::dapc_iter_rsp_t      rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic                          op_q;
	logic [dapc_pkg::CNT_W-1:0]    cnt_q;
	logic [21:0]                   rem_q;
	logic [dapc_pkg::NUM_W-1:0]    src_q;
	logic [dapc_pkg::NUM_W-1:0]    res_q;
	logic [dapc_pkg::DEN_W-1:0]    den_q;

	logic [21:0] rem_sh;
	logic [21:0] trial;
	logic [22:0] diff;
	logic        ge;

	// One step: bring down the next bit (division) or bit pair (root), then
	// try to subtract the divisor or the trial root.
	always_comb begin
		if (op_q == dapc_pkg::OP_SQRT) begin
			rem_sh = {rem_q[19:0], src_q[36:35]};
			trial  = {2'b00, res_q[17:0], 2'b01};
		end else begin
			rem_sh = {rem_q[20:0], src_q[36]};
			trial  = {1'b0, den_q};
		end
		diff = {1'b0, rem_sh} - {1'b0, trial};
		ge   = ~diff[22];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == dapc_pkg::OP_SQRT) ? dapc_pkg::SQRT_STEPS
				                                        : dapc_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			den_q <= req.den;
			rem_q <= '0;
			res_q <= '0;
			if (req.op == dapc_pkg::OP_SQRT) begin
				src_q <= {req.opnd[35:0], 1'b0};
			end else begin
				src_q <= req.opnd;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[21:0] : rem_sh;
			res_q <= {res_q[35:0], ge};
			if (op_q == dapc_pkg::OP_SQRT) begin
				src_q <= {src_q[34:0], 2'b00};
			end else begin
				src_q <= {src_q[35:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/delay_adaptive_p_controller.sv =====
// Top level of the delay-adaptive proportional joint controller.
//
// Each accepted input transaction carries one joint: its measured and target angle (Q4.16 rad)
// and the measured loop delay in microseconds, floored at 1000 us. The block forms
// omega = pi / (2 (delay + tau)) with the joint's fixed actuator time constant, the stability
// gain K = omega * sqrt(1 + (tau omega)^2) scaled by gain_margin, and returns one output
// transaction with K * (target - measured) as a saturated Q16 velocity command, the running
// maximum of |error| over the control cycle and, on the transaction marked tlast, the
// convergence verdict and a sticky reached flag. From acceptance to a loaded result an item
// runs two 37-step divisions on the shared divide/square-root unit, the squaring on the
// multiplier, one 18-step root on the same unit, then the three further products on the one
// shared multiplier and the output load. A new input transaction is taken only once the
// sequencer has returned to idle after the output load. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register without holding up the
// next input transaction. Configuration writes are always accepted and should be made only
// while the block is idle.
`default_nettype none

module delay_adaptive_p_controller (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input stream.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// s_tdata: measured_position[19:0], target_position[39:20], loop_delay_us[59:40], zero fill.
	input  wire logic [dapc_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: joint_index[2:0].
	input  wire logic [dapc_pkg::TUSER_W-1:0]   s_tuser,
	input  wire logic                           s_tlast,
	// Output stream.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// m_tdata: velocity_cmd[31:0], cycle_max_error[51:32], converged[52],
	// reached_latched[53], zero fill.
	output logic [dapc_pkg::M_TDATA_W-1:0]      m_tdata,
	// m_tuser: out_joint[2:0].
	output logic [dapc_pkg::TUSER_W-1:0]        m_tuser,
	output logic                                m_tlast,
	// Configuration write channel.
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dapc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [19:0]                    cfg_data
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_W_GO   = 4'd1;
	localparam logic [3:0] ST_W_WAIT = 4'd2;
	localparam logic [3:0] ST_X_GO   = 4'd3;
	localparam logic [3:0] ST_X_WAIT = 4'd4;
	localparam logic [3:0] ST_SQ_MUL = 4'd5;
	localparam logic [3:0] ST_R_GO   = 4'd6;
	localparam logic [3:0] ST_R_WAIT = 4'd7;
	localparam logic [3:0] ST_K1     = 4'd8;
	localparam logic [3:0] ST_K2     = 4'd9;
	localparam logic [3:0] ST_V      = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0]  state_q;
	logic [15:0] gain_margin_q;
	logic [19:0] error_threshold_q;
	logic [19:0] running_max_q;
	logic        reached_q;

	// Item registers.
	logic [2:0]  joint_q;
	logic [2:0]  jsel_q;
	logic        last_q;
	logic [20:0] s_q;
	logic [20:0] mag_q;
	logic        neg_q;
	logic [25:0] omega_q;
	logic [16:0] x_q;
	logic [35:0] rad_q;
	logic [17:0] root_q;
	logic [26:0] kraw_q;
	logic [26:0] k_q;
	logic [31:0] vel_q;

	// Output registers.
	logic                           m_tvalid_q;
	logic [dapc_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [dapc_pkg::TUSER_W-1:0]   m_tuser_q;
	logic                           m_tlast_q;

	logic                     in_fire;
	logic                     out_load;
	logic [2:0]               jsel;
	logic [19:0]              delay_fl;
	logic [20:0]              s_sum;
	logic signed [20:0]       err;
	logic [20:0]              mag;
	dapc_pkg::dapc_iter_req_t ireq;
	dapc_pkg::dapc_iter_rsp_t irsp;
	logic [26:0]              mul_a;
	logic [20:0]              mul_b;
	logic [47:0]              prod;
	logic [31:0]              vmag;
	logic [31:0]              vel;
	logic [19:0]              emag;
	logic [19:0]              cmax;
	logic                     conv;
	logic                     reached_nx;

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// Front end: joint clamp, delay floor, sum with tau and the position error.
	always_comb begin
		jsel = (s_tuser >= 3'(dapc_pkg::NUM_JOINTS)) ? 3'(dapc_pkg::NUM_JOINTS - 1) : s_tuser;
		delay_fl = (s_tdata[59:40] < dapc_pkg::DELAY_FLOOR_US) ? dapc_pkg::DELAY_FLOOR_US
		                                                       : s_tdata[59:40];
		s_sum = {1'b0, delay_fl} + {9'd0, dapc_pkg::joint_tau(jsel)};
		err   = $signed({s_tdata[39], s_tdata[39:20]}) - $signed({s_tdata[19], s_tdata[19:0]});
		mag   = err[20] ? (~err + 21'd1) : err;
	end

	// Requests to the shared divide/root unit.
	always_comb begin
		ireq.start = state_q inside {ST_W_GO, ST_X_GO, ST_R_GO};
		ireq.den   = s_q;
		case (state_q)
			ST_X_GO: begin
				ireq.op   = dapc_pkg::OP_DIV;
				ireq.opnd = dapc_pkg::joint_x_num(jsel_q);
			end
			ST_R_GO: begin
				ireq.op   = dapc_pkg::OP_SQRT;
				ireq.opnd = {1'b0, rad_q};
			end
			default: begin
				ireq.op   = dapc_pkg::OP_DIV;
				ireq.opnd = dapc_pkg::OMEGA_NUM;
			end
		endcase
	end

	dapc_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.rsp    (irsp)
	);

	// Shared multiplier: x*x, omega*root, kraw*margin and K*|error| in turn.
	always_comb begin
		case (state_q)
			ST_SQ_MUL: begin
				mul_a = {10'd0, x_q};
				mul_b = {4'd0, x_q};
			end
			ST_K1: begin
				mul_a = {1'b0, omega_q};
				mul_b = {3'd0, root_q};
			end
			ST_K2: begin
				mul_a = kraw_q;
				mul_b = {5'd0, gain_margin_q};
			end
			default: begin
				mul_a = k_q;
				mul_b = mag_q;
			end
		endcase
		prod = {21'd0, mul_a} * {27'd0, mul_b};
	end

	// Signed velocity with saturation to 32 bits.
	always_comb begin
		vmag = prod[47:16];
		if (neg_q) begin
			vel = (vmag > 32'h8000_0000) ? 32'h8000_0000 : (~vmag + 32'd1);
		end else begin
			vel = (vmag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : vmag;
		end
	end

	// Running maximum and the convergence verdict on the last joint.
	always_comb begin
		emag       = mag_q[20] ? dapc_pkg::MAX_ERR_SAT : mag_q[19:0];
		cmax       = (emag > running_max_q) ? emag : running_max_q;
		conv       = last_q && (cmax < error_threshold_q);
		reached_nx = reached_q || conv;
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			gain_margin_q     <= dapc_pkg::GAIN_MARGIN_RST;
			error_threshold_q <= dapc_pkg::ERROR_THRESHOLD_RST;
			running_max_q     <= '0;
			reached_q         <= 1'b0;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dapc_pkg::REG_GAIN_MARGIN:     gain_margin_q     <= cfg_data[15:0];
					dapc_pkg::REG_ERROR_THRESHOLD: error_threshold_q <= cfg_data;
					default: ;
				endcase
			end
			// Output valid: set when a result is loaded, cleared once it is taken.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:   if (in_fire) state_q <= ST_W_GO;
				ST_W_GO:   state_q <= ST_W_WAIT;
				ST_W_WAIT: if (irsp.done) state_q <= ST_X_GO;
				ST_X_GO:   state_q <= ST_X_WAIT;
				ST_X_WAIT: if (irsp.done) state_q <= ST_SQ_MUL;
				ST_SQ_MUL: state_q <= ST_R_GO;
				ST_R_GO:   state_q <= ST_R_WAIT;
				ST_R_WAIT: if (irsp.done) state_q <= ST_K1;
				ST_K1:     state_q <= ST_K2;
				ST_K2:     state_q <= ST_V;
				ST_V:      state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q       <= ST_IDLE;
						reached_q     <= reached_nx;
						running_max_q <= last_q ? 20'd0 : cmax;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			joint_q <= s_tuser;
			jsel_q  <= jsel;
			last_q  <= s_tlast;
			s_q     <= s_sum;
			mag_q   <= mag;
			neg_q   <= err[20];
		end
		if ((state_q == ST_W_WAIT) && irsp.done) begin
			omega_q <= irsp.res[25:0];
		end
		if ((state_q == ST_X_WAIT) && irsp.done) begin
			x_q <= irsp.res[16:0];
		end
		if ((state_q == ST_R_WAIT) && irsp.done) begin
			root_q <= irsp.res[17:0];
		end
		if (state_q == ST_SQ_MUL) begin
			rad_q <= {2'b00, prod[33:0]} + 36'h1_0000_0000;
		end
		if (state_q == ST_K1) begin
			kraw_q <= prod[42:16];
		end
		if (state_q == ST_K2) begin
			k_q <= prod[42:16];
		end
		if (state_q == ST_V) begin
			vel_q <= vel;
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, reached_nx, conv, cmax, vel_q};
			m_tuser_q <= joint_q;
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire
